[design/assert_macros.svh]
// Assertion macros shared by the convolution filter RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every rising clock edge outside reset
`define CVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset
`define CVC_NEVER(lbl, cond, msg) \
  `CVC_ASSERT(lbl, !(cond), msg)

`endif

[design/cvc_pkg.sv]
// Package for the 3x3 RGBA convolution filter: constants, payload and job types.
// No dependencies.
`timescale 1ns / 1ps
package cvc_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COEF_BITS = 16;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int LANE_W    = 16;
  localparam int QDEPTH    = 2;
  localparam int PROD_W    = COEF_BITS + 9;
  localparam int SUM_W     = 28;
  localparam int NUM_W     = SUM_W - 1;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // configuration register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KERNEL_TOP   = 3'd2;
  localparam logic [2:0] REG_KERNEL_MID   = 3'd3;
  localparam logic [2:0] REG_KERNEL_BOT   = 3'd4;
  localparam logic [2:0] REG_DIVISOR      = 3'd5;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
    logic [7:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic [7:0]  out_alpha;
    logic [15:0] out_row;
    logic [9:0]  out_col;
    logic        run_last;
    logic        frame_done;
  } pix_out_t;

  typedef struct packed {
    logic [10:0]                 image_width;
    logic [15:0]                 image_height;
    logic [2:0][2:0][LANE_W-1:0] kernel;   // [row][col], col 0 in low bits
    logic [15:0]                 divisor;
  } cfg_t;

  // One queued request: neighbourhood plus position and edge flags
  typedef struct packed {
    logic [2:0][2:0][31:0] grid;   // [row][col]
    logic [15:0]           row;
    logic [COL_W-1:0]      col;
    logic                  first_row;
    logic                  first_col;
    logic                  end_col;
    logic                  last_row;
  } job_t;

  typedef enum logic {F_IDLE, F_UPDATE} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_MAC, B_LOAD, B_DIV, B_OUT} back_state_t;

endpackage

[design/conv3x3_rgba_clamp_edge_replicate.sv]
// Channel  | ports                          | moves
// ---------+--------------------------------+--------------------------------
// input    | in_valid in_stall in_data      | one RGBA pixel, raster order
// result   | out_valid out_stall out_data   | filtered pixel with row and col
// config   | cfg_we cfg_index cfg_data      | register write, no read-back
//
// The front end takes a pixel, then updates its line stores and window before
// it takes the next, while the request queue has room. Each result passes
// through the back end in order: 9 multiply-accumulate steps, one load,
// 27 divide steps and one output step. The back end passes through its idle
// state before the first result of each request; one pixel may release up to
// four results. Reset is synchronous, active low. A stalled result holds in the
// output register; the queue then fills and in_stall rises.
// Top level: configuration registers, front end, queue, back end.
// Depends on cvc_pkg, cvc_front, cvc_queue and cvc_back.
`timescale 1ns / 1ps
module conv3x3_rgba_clamp_edge_replicate (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  cvc_pkg::pix_in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output cvc_pkg::pix_out_t out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [47:0]      cfg_data
);
  import cvc_pkg::*;

  cfg_t cfg_r;
  logic q_push, q_pop, q_empty, q_full;
  job_t q_wr, q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= 11'd2;
      cfg_r.image_height <= 16'd2;
      cfg_r.kernel       <= '0;
      cfg_r.divisor      <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[15:0];
        REG_KERNEL_TOP:   cfg_r.kernel[0]    <= cfg_data;
        REG_KERNEL_MID:   cfg_r.kernel[1]    <= cfg_data;
        REG_KERNEL_BOT:   cfg_r.kernel[2]    <= cfg_data;
        REG_DIVISOR:      cfg_r.divisor      <= cfg_data[15:0];
        default:          cfg_r.divisor      <= cfg_r.divisor;
      endcase
    end
  end

  cvc_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_full(q_full), .q_push(q_push), .q_entry(q_wr)
  );

  cvc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wr_entry(q_wr),
    .pop(q_pop), .head(q_head), .empty(q_empty), .full(q_full)
  );

  cvc_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .head(q_head), .q_empty(q_empty),
    .q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule

[design/cvc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

[design/cvc_front.sv]
// Front end: takes pixels, keeps line stores and window, queues neighbourhoods.
// Depends on cvc_pkg and cvc_ram.
`timescale 1ns / 1ps
module cvc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  cvc_pkg::cfg_t    cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  cvc_pkg::pix_in_t in_data,
  input  logic            q_full,
  output logic            q_push,
  output cvc_pkg::job_t    q_entry
);
  import cvc_pkg::*;

  front_state_t     state_r, state_nxt;
  word_t            cur_r;
  word_t            win_r [6];
  logic [15:0]      row_r;
  logic [COL_W-1:0] col_r;
  word_t            up_rd, lo_rd;
  logic             ram_we;
  logic             accept;
  logic [10:0]      w_eff;
  logic [15:0]      h_eff;
  logic             end_col, last_row;

  // line stores: upper holds row i-2, lower row i-1
  cvc_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(ram_we), .waddr(col_r), .wdata(lo_rd), .raddr(col_r), .rdata(up_rd)
  );
  cvc_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_lower (
    .clk(clk), .we(ram_we), .waddr(col_r), .wdata(cur_r), .raddr(col_r), .rdata(lo_rd)
  );

  // geometry with saturation
  always_comb begin
    if (cfg.image_width < 11'd2) w_eff = 11'd2;
    else if (cfg.image_width > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
    else w_eff = cfg.image_width;
    h_eff    = (cfg.image_height < 16'd2) ? 16'd2 : cfg.image_height;
    end_col  = ({1'b0, col_r} >= (w_eff - 11'd1));
    last_row = (row_r >= (h_eff - 16'd1));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:   if (accept) state_nxt = F_UPDATE;
      F_UPDATE: state_nxt = F_IDLE;
      default:  state_nxt = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state_r != F_IDLE) || q_full;
    accept   = in_valid && !in_stall;
    ram_we   = (state_r == F_UPDATE);
    q_push   = (state_r == F_UPDATE) && (row_r != 16'd0) && (col_r != '0);
    q_entry.grid[0]  = {up_rd, win_r[1], win_r[0]};
    q_entry.grid[1]  = {lo_rd, win_r[3], win_r[2]};
    q_entry.grid[2]  = {cur_r, win_r[5], win_r[4]};
    q_entry.row       = row_r - 16'd1;
    q_entry.col       = col_r - COL_W'(1);
    q_entry.first_row = (row_r == 16'd1);
    q_entry.first_col = (col_r == COL_W'(1));
    q_entry.end_col   = end_col;
    q_entry.last_row  = last_row;
  end

  // state, window and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      for (int k = 0; k < 6; k++) win_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_UPDATE) begin
        win_r[0] <= win_r[1];
        win_r[1] <= up_rd;
        win_r[2] <= win_r[3];
        win_r[3] <= lo_rd;
        win_r[4] <= win_r[5];
        win_r[5] <= cur_r;
        if (end_col) begin
          col_r <= '0;
          row_r <= last_row ? 16'd0 : row_r + 16'd1;
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
    end
  end

  // captured pixel, blue in the low byte
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r <= {in_data.in_alpha, in_data.in_red, in_data.in_green, in_data.in_blue};
    end
  end
endmodule

[design/cvc_queue.sv]
// Short request queue between front and back end.
// Depends on cvc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cvc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cvc_pkg::job_t  wr_entry,
  input  logic          pop,
  output cvc_pkg::job_t  head,
  output logic          empty,
  output logic          full
);
  import cvc_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  job_t          mem_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(QDEPTH));
  assign head  = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (pop)  rp_r <= (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + PW'(1);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_entry;
  end

  `CVC_NEVER(a_no_overflow, push && full, "queue push while full")
  `CVC_NEVER(a_no_underflow, pop && empty, "queue pop while empty")
endmodule

[design/cvc_back.sv]
// Back end: per result, 9-tap multiply-accumulate, serial divide, clamp, output reg.
// Depends on cvc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cvc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  cvc_pkg::cfg_t     cfg,
  input  cvc_pkg::job_t     head,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output cvc_pkg::pix_out_t out_data
);
  import cvc_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [1:0]        sub_r;            // [1] next row, [0] next column
  logic [1:0]        ta_r, tb_r;
  logic [CNT_W-1:0]  cnt_r;
  logic signed [SUM_W-1:0] acc_r [4];
  logic [NUM_W-1:0]  num_r [4];
  logic [NUM_W-1:0]  quo_r [4];
  logic [15:0]       rem_r [4];
  logic              out_valid_r;
  pix_out_t          out_data_r;

  logic              has_next;
  logic [1:0]        next_sub;
  logic              last_tap, out_free, do_out;
  logic [1:0]        tr, tc;
  word_t             pix;
  logic signed [COEF_BITS-1:0] wt;
  logic signed [PROD_W-1:0]    prod [4];
  logic [15:0]       dv;
  logic [7:0]        res [4];

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign dv        = (cfg.divisor == 16'd0) ? 16'd1 : cfg.divisor;
  assign last_tap  = (ta_r == 2'd2) && (tb_r == 2'd2);
  assign out_free  = !out_valid_r || !out_stall;

  // order of results released by one request
  always_comb begin
    has_next = 1'b0;
    next_sub = sub_r;
    unique case (sub_r)
      2'b00: begin
        if (head.end_col) begin
          has_next = 1'b1; next_sub = 2'b01;
        end else if (head.last_row) begin
          has_next = 1'b1; next_sub = 2'b10;
        end
      end
      2'b01: if (head.last_row) begin
        has_next = 1'b1; next_sub = 2'b10;
      end
      2'b10: if (head.end_col) begin
        has_next = 1'b1; next_sub = 2'b11;
      end
      default: has_next = 1'b0;
    endcase
  end

  // edge replicated tap selection and products
  always_comb begin
    if (sub_r[1]) tr = (ta_r == 2'd0) ? 2'd1 : 2'd2;
    else tr = (ta_r == 2'd0 && head.first_row) ? 2'd1 : ta_r;
    if (sub_r[0]) tc = (tb_r == 2'd0) ? 2'd1 : 2'd2;
    else tc = (tb_r == 2'd0 && head.first_col) ? 2'd1 : tb_r;
    pix = head.grid[tr][tc];
    wt  = $signed(cfg.kernel[ta_r][tb_r][COEF_BITS-1:0]);
    for (int c = 0; c < 4; c++) begin
      prod[c] = wt * $signed({1'b0, pix[8*c +: 8]});
    end
  end

  // clamp of the quotients
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      res[c] = (quo_r[c] > NUM_W'(255)) ? 8'd255 : quo_r[c][7:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = B_MAC;
      B_MAC:   if (last_tap) state_nxt = B_LOAD;
      B_LOAD:  state_nxt = B_DIV;
      B_DIV:   if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = B_OUT;
      B_OUT:   if (out_free) state_nxt = has_next ? B_MAC : B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    do_out = (state_r == B_OUT) && out_free;
    q_pop  = do_out && !has_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      sub_r       <= '0;
      ta_r        <= '0;
      tb_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_IDLE) begin
        sub_r <= '0;
        ta_r  <= '0;
        tb_r  <= '0;
      end else if (state_r == B_MAC) begin
        if (tb_r == 2'd2) begin
          tb_r <= '0;
          ta_r <= ta_r + 2'd1;
        end else begin
          tb_r <= tb_r + 2'd1;
        end
      end else if (state_r == B_LOAD) begin
        cnt_r <= '0;
      end else if (state_r == B_DIV) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_out) begin
        sub_r <= next_sub;
        ta_r  <= '0;
        tb_r  <= '0;
      end
      if (do_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath: accumulate, then restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      if (state_r == B_IDLE || do_out) begin
        acc_r[c] <= '0;
      end else if (state_r == B_MAC) begin
        acc_r[c] <= acc_r[c] + SUM_W'(prod[c]);
      end else if (state_r == B_LOAD) begin
        // a non-positive sum gives a quotient that clamps to zero
        num_r[c] <= (acc_r[c] > 0) ? acc_r[c][NUM_W-1:0] : '0;
        rem_r[c] <= '0;
        quo_r[c] <= '0;
      end else if (state_r == B_DIV) begin
        logic [16:0] rsh;
        logic [17:0] diff;
        rsh  = {rem_r[c], num_r[c][NUM_W-1]};
        diff = {1'b0, rsh} - {2'b00, dv};
        num_r[c] <= {num_r[c][NUM_W-2:0], 1'b0};
        if (!diff[17]) begin
          rem_r[c] <= diff[15:0];
          quo_r[c] <= {quo_r[c][NUM_W-2:0], 1'b1};
        end else begin
          rem_r[c] <= rsh[15:0];
          quo_r[c] <= {quo_r[c][NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (do_out) begin
      out_data_r.out_blue   <= res[0];
      out_data_r.out_green  <= res[1];
      out_data_r.out_red    <= res[2];
      out_data_r.out_alpha  <= res[3];
      out_data_r.out_row    <= head.row + {15'd0, sub_r[1]};
      out_data_r.out_col    <= head.col + {{(COL_W-1){1'b0}}, sub_r[0]};
      out_data_r.run_last   <= !has_next;
      out_data_r.frame_done <= (sub_r == 2'b11);
    end
  end

  `CVC_NEVER(a_work_has_request, (state_r != B_IDLE) && q_empty,
             "back end working without a queued request")
endmodule

[tb/tb_conv3x3_rgba_clamp_edge_replicate.sv]
// Testbench for the 3x3 RGBA convolution filter with edge replication.
// Checks every output pixel against a behavioral filter model; needs cvc_pkg and the RTL.
`timescale 1ns / 1ps
module tb_conv3x3_rgba_clamp_edge_replicate;
  import cvc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  pix_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  pix_out_t    out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  conv3x3_rgba_clamp_edge_replicate dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // filter model state
  logic [10:0] m_width;
  logic [15:0] m_height;
  logic [47:0] m_kern [3];
  logic [15:0] m_div;
  word_t       m_upper [MAX_WIDTH];
  word_t       m_lower [MAX_WIDTH];
  word_t       m_win [6];
  int unsigned m_row, m_col;

  pix_out_t pending_pix [$];
  int       failures;
  bit       idle_free;
  int       watchdog;

  function automatic int signed weight(int a, int b);
    logic [15:0] lane;
    lane = m_kern[a][16*b +: 16];
    return $signed(lane);
  endfunction

  function automatic pix_out_t filter_pix(word_t g [3][3], int tr [3], int tc [3],
                                          int unsigned r, int unsigned c);
    pix_out_t p;
    longint sum, q, dv;
    dv = (m_div == 0) ? 1 : m_div;
    p = '0;
    for (int ch = 0; ch < 4; ch++) begin
      sum = 0;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++)
          sum += longint'(weight(a, b)) * longint'(g[tr[a]][tc[b]][8*ch +: 8]);
      q = sum / dv;
      if (q > 255) q = 255;
      else if (q < 0) q = 0;
      case (ch)
        0: p.out_blue = q[7:0];
        1: p.out_green = q[7:0];
        2: p.out_red = q[7:0];
        default: p.out_alpha = q[7:0];
      endcase
    end
    p.out_row = r[15:0];
    p.out_col = c[9:0];
    return p;
  endfunction

  // advance the model by one pixel and queue the outputs it releases
  task automatic predict_pixel(pix_in_t px);
    int unsigned w, h, i, j;
    word_t cur, up, lo;
    word_t g [3][3];
    int tr [3], tc [3];
    bit end_col, last_row;
    pix_out_t res [$];
    w = m_width; h = m_height;
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 2) h = 2;
    i = m_row; j = m_col;
    if (j >= MAX_WIDTH) j = MAX_WIDTH - 1;
    cur = {px.in_alpha, px.in_red, px.in_green, px.in_blue};
    up = m_upper[j]; lo = m_lower[j];
    g[0] = '{m_win[0], m_win[1], up};
    g[1] = '{m_win[2], m_win[3], lo};
    g[2] = '{m_win[4], m_win[5], cur};
    end_col = (j >= w - 1);
    last_row = (i >= h - 1);
    if (i >= 1 && j >= 1) begin
      tr = '{(i == 1) ? 1 : 0, 1, 2};
      tc = '{(j == 1) ? 1 : 0, 1, 2};
      res.push_back(filter_pix(g, tr, tc, i - 1, j - 1));
      if (end_col) begin
        tc = '{1, 2, 2};
        res.push_back(filter_pix(g, tr, tc, i - 1, j));
      end
      if (last_row) begin
        tr = '{1, 2, 2};
        tc = '{(j == 1) ? 1 : 0, 1, 2};
        res.push_back(filter_pix(g, tr, tc, i, j - 1));
        if (end_col) begin
          tc = '{1, 2, 2};
          res.push_back(filter_pix(g, tr, tc, i, j));
          res[res.size()-1].frame_done = 1'b1;
        end
      end
    end
    if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
    foreach (res[k]) pending_pix.push_back(res[k]);
    m_win[0] = m_win[1]; m_win[1] = up;
    m_win[2] = m_win[3]; m_win[3] = lo;
    m_win[4] = m_win[5]; m_win[5] = cur;
    m_upper[j] = lo;
    m_lower[j] = cur;
    if (end_col) begin
      m_col = 0;
      m_row = last_row ? 0 : ((i + 1) & 16'hFFFF);
    end else begin
      m_col = j + 1;
    end
  endtask

  // register write, mirrored into the model
  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  m_width = val[10:0];
      REG_IMAGE_HEIGHT: m_height = val[15:0];
      REG_KERNEL_TOP:   m_kern[0] = val;
      REG_KERNEL_MID:   m_kern[1] = val;
      REG_KERNEL_BOT:   m_kern[2] = val;
      REG_DIVISOR:      m_div = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_filter(logic [10:0] w, logic [15:0] h, logic [47:0] kt,
                            logic [47:0] km, logic [47:0] kb, logic [15:0] dv);
    write_reg(REG_IMAGE_WIDTH, {37'd0, w});
    write_reg(REG_IMAGE_HEIGHT, {32'd0, h});
    write_reg(REG_KERNEL_TOP, kt);
    write_reg(REG_KERNEL_MID, km);
    write_reg(REG_KERNEL_BOT, kb);
    write_reg(REG_DIVISOR, {32'd0, dv});
  endtask

  // drop the input and wait until the filter has drained every pending output
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_pix.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic bit idle_now();
    return !idle_free && ($urandom_range(99) < 18);
  endfunction

  // push one pixel request through the input handshake; valid stays up
  // until the next request or drain sets it
  task automatic send_pixel(pix_in_t px);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixel(px);
    @(negedge clk);
  endtask

  function automatic pix_in_t rand_pixel();
    return pix_in_t'($urandom);
  endfunction

  function automatic logic [47:0] rand_kernel_row();
    logic [47:0] v;
    v = {$urandom, $urandom};
    for (int b = 0; b < 3; b++)
      if ($urandom_range(3) != 0) v[16*b +: 16] = 16'($signed($urandom_range(16)) - 8);
    return v;
  endfunction

  task automatic send_frame(int unsigned w, int unsigned h);
    for (int unsigned n = 0; n < w * h; n++) send_pixel(rand_pixel());
  endtask

  // result side: random stall, compare against oldest expectation
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= idle_now();
  end

  always @(posedge clk) begin
    pix_out_t exp_pix;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pix.size() == 0) begin
        $error("unexpected output row %0d col %0d", out_data.out_row, out_data.out_col);
        failures++;
      end else begin
        exp_pix = pending_pix.pop_front();
        if (out_data.out_blue !== exp_pix.out_blue) begin
          $error("out_blue exp %0d got %0d", exp_pix.out_blue, out_data.out_blue);
          failures++;
        end
        if (out_data.out_green !== exp_pix.out_green) begin
          $error("out_green exp %0d got %0d", exp_pix.out_green, out_data.out_green);
          failures++;
        end
        if (out_data.out_red !== exp_pix.out_red) begin
          $error("out_red exp %0d got %0d", exp_pix.out_red, out_data.out_red);
          failures++;
        end
        if (out_data.out_alpha !== exp_pix.out_alpha) begin
          $error("out_alpha exp %0d got %0d", exp_pix.out_alpha, out_data.out_alpha);
          failures++;
        end
        if (out_data.out_row !== exp_pix.out_row) begin
          $error("out_row exp %0d got %0d", exp_pix.out_row, out_data.out_row);
          failures++;
        end
        if (out_data.out_col !== exp_pix.out_col) begin
          $error("out_col exp %0d got %0d", exp_pix.out_col, out_data.out_col);
          failures++;
        end
        if (out_data.run_last !== exp_pix.run_last) begin
          $error("run_last exp %0d got %0d", exp_pix.run_last, out_data.run_last);
          failures++;
        end
        if (out_data.frame_done !== exp_pix.frame_done) begin
          $error("frame_done exp %0d got %0d", exp_pix.frame_done, out_data.frame_done);
          failures++;
        end
      end
    end
  end

  // watchdog: cycles without any accepted input pixel or output result
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog > 20000) begin
      $display("tb_conv3x3_rgba_clamp_edge_replicate NOT OK");
      $finish;
    end
  end

  // directed rows: one 2x2 frame each
  typedef struct {
    logic [47:0] kt, km, kb;
    logic [15:0] dv;
    pix_in_t     px;
  } dir_row_t;

  dir_row_t dir_tab [6];

  initial begin
    failures = 0; watchdog = 0; idle_free = 1'b0;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_IMAGE_WIDTH; cfg_data = '0;
    m_width = 2; m_height = 2; m_div = 1;
    foreach (m_kern[a]) m_kern[a] = '0;
    foreach (m_win[k]) m_win[k] = '0;
    foreach (m_upper[k]) begin m_upper[k] = '0; m_lower[k] = '0; end
    m_row = 0; m_col = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset kernel is all zeros: every output is 0
    for (int n = 0; n < 4; n++) send_pixel(rand_pixel());
    drain();

    // identity, max positive, max negative, divisor extremes, box blur, mixed-sign kernel
    dir_tab[0] = '{48'h0, 48'h0000_0001_0000, 48'h0, 16'd1, '1};
    dir_tab[1] = '{48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 16'd1, '1};
    dir_tab[2] = '{48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 16'd1, '1};
    dir_tab[3] = '{48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                   16'hFFFF, 32'h80FF_7F01};
    dir_tab[4] = '{48'h0001_0001_0001, 48'h0001_0001_0001, 48'h0001_0001_0001,
                   16'd0, 32'h0102_0408};
    dir_tab[5] = '{48'hFFFF_0000_0001, 48'h0002_FFFE_0003, 48'h0000_FFFF_0001,
                   16'd3, 32'h00FF_00FF};
    foreach (dir_tab[r]) begin
      set_filter(11'd2, 16'd2, dir_tab[r].kt, dir_tab[r].km, dir_tab[r].kb, dir_tab[r].dv);
      send_pixel(dir_tab[r].px);
      send_pixel('0);
      send_pixel(~dir_tab[r].px);
      send_pixel(rand_pixel());
      drain();
    end

    // out-of-range geometry: width 0 and 1 saturate to 2, height 0 and 1 to 2
    set_filter(11'd0, 16'd0, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(), 16'd4);
    send_frame(2, 2);
    drain();
    set_filter(11'd1, 16'd1, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(), 16'd2);
    send_frame(2, 2);
    drain();

    // random frames, all small; one stretch without idling
    for (int f = 0; f < 14; f++) begin
      int unsigned w, h;
      w = $urandom_range(2, 6);
      h = $urandom_range(2, 5);
      idle_free = (f >= 5 && f < 8);
      set_filter(w[10:0], h[15:0], rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 16)));
      send_frame(w, h);
      drain();
    end
    idle_free = 1'b0;

    // one wide line: 64 columns, height 2 (128 pixels)
    set_filter(11'd64, 16'd2, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(), 16'd9);
    send_frame(64, 2);
    drain();

    // tall, narrow image with large height register: partial frame, then width change
    set_filter(11'd3, 16'hFFFF, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(), 16'd5);
    send_frame(3, 6);
    drain();
    set_filter(11'd2, 16'd2, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(), 16'd1);
    send_frame(2, 3);
    drain();

    if (failures == 0)
      $display("tb_conv3x3_rgba_clamp_edge_replicate OK");
    else
      $display("tb_conv3x3_rgba_clamp_edge_replicate NOT OK");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/cvc_pkg.sv
design/cvc_ram.sv
design/cvc_front.sv
design/cvc_queue.sv
design/cvc_back.sv
design/conv3x3_rgba_clamp_edge_replicate.sv
tb/tb_conv3x3_rgba_clamp_edge_replicate.sv
